@@ rtl/mrqs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrqs_pkg
// Shared types, constants and helpers for the multilevel ready-queue
// scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mrqs_pkg;

    localparam int NUM_LEVELS  = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W     = 8;
    localparam int SLOT_W   = 8;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;
    localparam int POL_W    = 2;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    typedef logic [LVL_IDX_W-1:0] t_lvl;
    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [ID_W-1:0]      t_id;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [PRIO_W-1:0]    t_prio;
    typedef logic [POL_W-1:0]     t_policy;
    typedef logic [NUM_LEVELS-1:0] t_lvl_mask;

    localparam t_policy POL_FIFO = 2'd0;
    localparam t_policy POL_RR   = 2'd1;
    localparam t_policy POL_PRIO = 2'd2;

    localparam logic KIND_ENQ  = 1'b0;
    localparam logic KIND_DISP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED   = 2'd0,
        ST_DISPATCHED = 2'd1,
        ST_IDLE       = 2'd2,
        ST_DROPPED    = 2'd3
    } t_status;

    typedef struct packed {
        logic kind;
        t_slot slot;
        t_id   id;
        t_prio prio;
        logic  work;
    } t_item;

    typedef struct packed {
        logic we;
        t_lvl wlvl;
        t_ptr wptr;
        t_id  wdata;
        logic re;
        t_lvl rlvl;
        t_ptr rptr;
    } t_mem_req;

    typedef struct packed {
        t_status status;
        t_slot   slot;
        logic    pop;
        logic    fwd;
        t_id     fwd_id;
        t_prio   level;
    } t_res;

    function automatic t_lvl highest_busy(input t_lvl_mask busy, input t_lvl top);
        t_lvl res;
        res = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (busy[i] && (i <= int'(top))) begin
                res = t_lvl'(i);
            end
        end
        return res;
    endfunction

    function automatic t_ptr ptr_inc(input t_ptr p);
        t_ptr res;
        if (int'(p) + 1 >= QUEUE_DEPTH) begin
            res = '0;
        end else begin
            res = t_ptr'(int'(p) + 1);
        end
        return res;
    endfunction

    function automatic t_lvl clamp_level(input t_prio p);
        t_lvl res;
        if (int'(p) >= NUM_LEVELS) begin
            res = t_lvl'(NUM_LEVELS - 1);
        end else begin
            res = t_lvl'(p);
        end
        return res;
    endfunction

    function automatic t_prio lvl_to_field(input t_lvl l);
        return t_prio'(int'(l) & 7);
    endfunction

endpackage

`default_nettype wire

@@ rtl/mrqs_store.sv @@
// ----------------------------------------------------------------------------
// mrqs_store
// Id storage for all levels, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mrqs_store (
    input  wire logic              i_clk,
    input  wire mrqs_pkg::t_mem_req i_req,
    output mrqs_pkg::t_id          o_rd_data
);

    mrqs_pkg::t_id r_mem [mrqs_pkg::NUM_LEVELS][mrqs_pkg::QUEUE_DEPTH];
    mrqs_pkg::t_id r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wlvl][i_req.wptr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.rlvl][i_req.rptr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/mrqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrqs_ctrl
// Queue pointers, fill counts, top level and policy; decides push, pop and
// status for each accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mrqs_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire mrqs_pkg::t_policy   i_cfg_wr_data,
    input  wire logic                i_accept,
    input  wire mrqs_pkg::t_item     i_item,
    output mrqs_pkg::t_mem_req       o_mem_req,
    output mrqs_pkg::t_res           o_res
);

    mrqs_pkg::t_ptr    r_head [mrqs_pkg::NUM_LEVELS];
    mrqs_pkg::t_ptr    r_tail [mrqs_pkg::NUM_LEVELS];
    mrqs_pkg::t_cnt    r_fill [mrqs_pkg::NUM_LEVELS];
    mrqs_pkg::t_lvl    r_top;
    mrqs_pkg::t_policy r_policy;

    mrqs_pkg::t_ptr    n_head [mrqs_pkg::NUM_LEVELS];
    mrqs_pkg::t_ptr    n_tail [mrqs_pkg::NUM_LEVELS];
    mrqs_pkg::t_cnt    n_fill [mrqs_pkg::NUM_LEVELS];
    mrqs_pkg::t_lvl    n_top;

    mrqs_pkg::t_lvl      lvl;
    mrqs_pkg::t_lvl      src;
    mrqs_pkg::t_lvl      top_mid;
    mrqs_pkg::t_lvl_mask busy_mid;
    mrqs_pkg::t_lvl_mask busy_end;
    mrqs_pkg::t_cnt      fill_mid [mrqs_pkg::NUM_LEVELS];
    logic                want_push;
    logic                full;
    logic                do_push;
    logic                drop;
    logic                pop;
    logic                prio_mode;

    always_comb begin
        lvl       = mrqs_pkg::clamp_level(i_item.prio);
        full      = (int'(r_fill[lvl]) >= mrqs_pkg::QUEUE_DEPTH);
        prio_mode = (r_policy == mrqs_pkg::POL_PRIO);
        if (i_item.kind == mrqs_pkg::KIND_ENQ) begin
            want_push = 1'b1;
        end else begin
            want_push = ((r_policy == mrqs_pkg::POL_RR) || prio_mode) &&
                        (i_item.id != '0) && i_item.work;
        end
        do_push = want_push && !full;
        drop    = want_push && full;

        for (int i = 0; i < mrqs_pkg::NUM_LEVELS; i++) begin
            fill_mid[i] = r_fill[i];
            if (do_push && (int'(lvl) == i)) begin
                fill_mid[i] = r_fill[i] + mrqs_pkg::t_cnt'(1);
            end
            busy_mid[i] = (fill_mid[i] != '0);
        end

        top_mid = r_top;
        if (do_push && (lvl > r_top)) begin
            top_mid = lvl;
        end

        src = '0;
        if (prio_mode) begin
            src = mrqs_pkg::highest_busy(busy_mid, top_mid);
        end
        pop = (i_item.kind == mrqs_pkg::KIND_DISP) && busy_mid[src];

        for (int i = 0; i < mrqs_pkg::NUM_LEVELS; i++) begin
            n_head[i] = r_head[i];
            n_tail[i] = r_tail[i];
            n_fill[i] = fill_mid[i];
            if (do_push && (int'(lvl) == i)) begin
                n_tail[i] = mrqs_pkg::ptr_inc(r_tail[i]);
            end
            if (pop && (int'(src) == i)) begin
                n_head[i] = mrqs_pkg::ptr_inc(r_head[i]);
                n_fill[i] = fill_mid[i] - mrqs_pkg::t_cnt'(1);
            end
            busy_end[i] = (n_fill[i] != '0);
        end

        n_top = top_mid;
        if (prio_mode && (i_item.kind == mrqs_pkg::KIND_DISP)) begin
            n_top = mrqs_pkg::highest_busy(busy_end, top_mid);
        end

        o_mem_req.we    = i_accept && do_push;
        o_mem_req.wlvl  = lvl;
        o_mem_req.wptr  = r_tail[lvl];
        o_mem_req.wdata = i_item.id;
        o_mem_req.re    = i_accept && pop;
        o_mem_req.rlvl  = src;
        o_mem_req.rptr  = r_head[src];

        o_res.slot   = i_item.slot;
        o_res.pop    = pop;
        o_res.fwd    = do_push && (lvl == src) && (r_fill[src] == '0);
        o_res.fwd_id = i_item.id;
        o_res.level  = pop ? mrqs_pkg::lvl_to_field(src) : '0;
        if (drop) begin
            o_res.status = mrqs_pkg::ST_DROPPED;
        end else if (i_item.kind == mrqs_pkg::KIND_ENQ) begin
            o_res.status = mrqs_pkg::ST_ENQUEUED;
        end else if (pop) begin
            o_res.status = mrqs_pkg::ST_DISPATCHED;
        end else begin
            o_res.status = mrqs_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mrqs_pkg::NUM_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
            r_top    <= mrqs_pkg::t_lvl'(mrqs_pkg::NUM_LEVELS - 1);
            r_policy <= mrqs_pkg::POL_FIFO;
        end else begin
            if (i_accept) begin
                for (int i = 0; i < mrqs_pkg::NUM_LEVELS; i++) begin
                    r_head[i] <= n_head[i];
                    r_tail[i] <= n_tail[i];
                    r_fill[i] <= n_fill[i];
                end
                r_top <= n_top;
            end
            if (i_cfg_wr_en) begin
                r_policy <= i_cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/multilevel_ready_queue_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// multilevel_ready_queue_scheduler_top
// Multilevel ready-queue scheduler with one id FIFO per priority level.
// ----------------------------------------------------------------------------
// Every input beat produces exactly one registered result beat. A new beat
// is taken in every cycle while the result register is empty or being
// drained, so the sustained rate is one item per clock; the queue update,
// level selection and store access all complete in the accepting cycle. The
// popped id is the registered store read, or the input id if queue was empty.
`default_nettype none

module multilevel_ready_queue_scheduler_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [mrqs_pkg::POL_W-1:0]      i_cfg_wr_data,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // thread_slot, proc_id, proc_priority, has_work_left
    input  wire logic [mrqs_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  wire logic                            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // slot_echo, granted_id, granted_level
    output logic [mrqs_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // status
    output logic [mrqs_pkg::STATUS_W-1:0]        o_m_axis_tuser
);

    mrqs_pkg::t_item    item;
    mrqs_pkg::t_mem_req mem_req;
    mrqs_pkg::t_res     res;
    mrqs_pkg::t_id      rd_data;
    mrqs_pkg::t_id      gid;
    mrqs_pkg::t_res     r_res;
    logic               r_valid;
    logic               accept;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign item.kind = i_s_axis_tuser;
    assign item.slot = i_s_axis_tdata[7:0];
    assign item.id   = i_s_axis_tdata[15:8];
    assign item.prio = i_s_axis_tdata[18:16];
    assign item.work = i_s_axis_tdata[19];

    mrqs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_item        (item),
        .o_mem_req     (mem_req),
        .o_res         (res)
    );

    mrqs_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    always_comb begin
        if (!r_res.pop) begin
            gid = '0;
        end else if (r_res.fwd) begin
            gid = r_res.fwd_id;
        end else begin
            gid = rd_data;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {5'd0, r_res.level, gid, r_res.slot};
    assign o_m_axis_tuser  = r_res.status;

endmodule

`default_nettype wire
